FILE: rtl/joint_feedback_table_core_assert.svh
// assertion macros shared by the joint feedback table rtl
// no dependencies; include by bare file name
`ifndef JOINT_FEEDBACK_TABLE_CORE_ASSERT_SVH
`define JOINT_FEEDBACK_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("joint feedback table assertion failed");

// next-cycle implication, disabled during reset
`define JFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("joint feedback table assertion failed");

`endif

FILE: rtl/jft_pkg.sv
// types, codes and field helpers for the joint feedback table
// used by every rtl module of the block; no dependencies
package jft_pkg;

    localparam int JOINT_COUNT = 7;
    localparam int JIDX_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam logic [JIDX_W-1:0] LAST_JOINT = JIDX_W'(JOINT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_NON_FINITE     = 3'd1,
        ST_UNKNOWN_BUS    = 3'd2,
        ST_MOTOR_MISMATCH = 3'd3,
        ST_STALE          = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_BUS_IDS_LOW  = 2'd0,
        CFG_BUS_IDS_HIGH = 2'd1,
        CFG_MOTOR_IDS    = 2'd2,
        CFG_STALE_LIMIT  = 2'd3
    } t_cfg_reg;

    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_SNAPSHOT = 1'b1;

    typedef struct packed {
        logic [43:0] bus_ids_low;
        logic [32:0] bus_ids_high;
        logic [55:0] motor_ids;
        logic [31:0] stale_limit_us;
    } t_cfg;

    typedef struct packed {
        logic [63:0] time_us;
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] torque;
        logic [31:0] driver_temp;
        logic [31:0] rotor_temp;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [JIDX_W-1:0] idx;
        t_entry            entry;
    } t_store_req;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_store_rsp;

    typedef struct packed {
        logic zero;
        logic borrow;
    } t_alu_flags;

    function automatic logic non_finite(input logic [31:0] v);
        return &v[30:23];
    endfunction

    function automatic logic [10:0] joint_bus(input t_cfg cfg, input logic [2:0] j);
        logic [10:0] id;
        case (j)
            3'd0:    id = cfg.bus_ids_low[10:0];
            3'd1:    id = cfg.bus_ids_low[21:11];
            3'd2:    id = cfg.bus_ids_low[32:22];
            3'd3:    id = cfg.bus_ids_low[43:33];
            3'd4:    id = cfg.bus_ids_high[10:0];
            3'd5:    id = cfg.bus_ids_high[21:11];
            3'd6:    id = cfg.bus_ids_high[32:22];
            default: id = '0;
        endcase
        return id;
    endfunction

    function automatic logic [7:0] joint_motor(input logic [55:0] m, input logic [2:0] j);
        logic [7:0] id;
        case (j)
            3'd0:    id = m[7:0];
            3'd1:    id = m[15:8];
            3'd2:    id = m[23:16];
            3'd3:    id = m[31:24];
            3'd4:    id = m[39:32];
            3'd5:    id = m[47:40];
            3'd6:    id = m[55:48];
            default: id = '0;
        endcase
        return id;
    endfunction

endpackage

FILE: rtl/jft_alu.sv
// shared 64-bit subtract unit with zero and borrow flags
// depends on jft_pkg
module jft_alu import jft_pkg::*; (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_diff,
    output t_alu_flags  o_flags
);

    logic [64:0] w_diff;

    assign w_diff         = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff         = w_diff[63:0];
    assign o_flags.borrow = w_diff[64];
    assign o_flags.zero   = (w_diff[63:0] == 64'd0);

endmodule

FILE: rtl/jft_store.sv
// per-joint sample entries with valid flags; invalid entries read as zero
// depends on jft_pkg
module jft_store import jft_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output t_store_rsp o_rsp
);

    t_entry                 r_entry [JOINT_COUNT];
    logic [JOINT_COUNT-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_entry[i_req.idx] <= i_req.entry;
        end
    end

    assign o_rsp.valid = r_valid[i_req.idx];
    assign o_rsp.entry = r_valid[i_req.idx] ? r_entry[i_req.idx] : '0;

endmodule

FILE: rtl/jft_ctrl.sv
// sequencer: request capture, joint scan, checks, commit and result register
// depends on jft_pkg; drives the shared subtract unit and the entry store
module jft_ctrl import jft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [10:0] i_bus_id,
    input  logic [7:0]  i_motor_id,
    input  t_entry      i_sample,
    output logic [63:0] o_alu_a,
    output logic [63:0] o_alu_b,
    input  logic [63:0] i_alu_diff,
    input  t_alu_flags  i_alu_flags,
    output t_store_req  o_store_req,
    input  t_store_rsp  i_store_rsp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_joint,
    output logic        o_last,
    output logic        o_fresh,
    output logic [31:0] o_generation,
    output logic        o_bus_active,
    output t_entry      o_entry
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_MOTOR = 8'b0000_0100,
        S_TIME  = 8'b0000_1000,
        S_LOAD  = 8'b0001_0000,
        S_SNAP  = 8'b0010_0000,
        S_AGE   = 8'b0100_0000,
        S_HOLD  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic              r_op, n_op;
    logic [10:0]       r_bus, n_bus;
    logic [7:0]        r_motor, n_motor;
    t_entry            r_sample, n_sample;
    logic              r_bad, n_bad;
    logic              r_have, n_have;
    logic [JIDX_W-1:0] r_joint, n_joint;
    t_status           r_status, n_status;
    logic [63:0]       r_diff, n_diff;
    logic              r_nb, n_nb;
    logic [31:0]       r_gen, n_gen;
    logic              r_active, n_active;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [2:0]        r_out_joint, n_out_joint;
    logic              r_out_last, n_out_last;
    logic              r_out_fresh, n_out_fresh;
    t_entry            r_out_entry, n_out_entry;
    logic              w_bad_in;

    assign w_bad_in = non_finite(i_sample.position) | non_finite(i_sample.velocity) |
                      non_finite(i_sample.torque) | non_finite(i_sample.driver_temp) |
                      non_finite(i_sample.rotor_temp);

    // operand select for the shared unit
    always_comb begin
        case (r_state)
            S_SCAN: begin
                o_alu_a = 64'(r_bus);
                o_alu_b = 64'(joint_bus(i_cfg, 3'(r_joint)));
            end
            S_MOTOR: begin
                o_alu_a = 64'(r_motor);
                o_alu_b = 64'(joint_motor(i_cfg.motor_ids, 3'(r_joint)));
            end
            S_TIME, S_SNAP: begin
                o_alu_a = r_sample.time_us;
                o_alu_b = i_store_rsp.entry.time_us;
            end
            S_AGE: begin
                o_alu_a = 64'(i_cfg.stale_limit_us);
                o_alu_b = r_diff;
            end
            default: begin
                o_alu_a = '0;
                o_alu_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_bus        = r_bus;
        n_motor      = r_motor;
        n_sample     = r_sample;
        n_bad        = r_bad;
        n_have       = r_have;
        n_joint      = r_joint;
        n_status     = r_status;
        n_diff       = r_diff;
        n_nb         = r_nb;
        n_gen        = r_gen;
        n_active     = r_active;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_joint  = r_out_joint;
        n_out_last   = r_out_last;
        n_out_fresh  = r_out_fresh;
        n_out_entry  = r_out_entry;
        o_in_ready   = 1'b0;
        o_store_req.we    = 1'b0;
        o_store_req.idx   = r_joint;
        o_store_req.entry = r_sample;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = i_operation;
                    n_bus    = i_bus_id;
                    n_motor  = i_motor_id;
                    n_sample = i_sample;
                    n_bad    = w_bad_in;
                    n_have   = 1'b0;
                    n_joint  = '0;
                    n_state  = (i_operation == OP_SNAPSHOT) ? S_SNAP : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_alu_flags.zero) begin
                    n_have  = 1'b1;
                    n_state = S_MOTOR;
                end else if (r_joint == LAST_JOINT) begin
                    n_joint  = '0;
                    n_status = r_bad ? ST_NON_FINITE : ST_UNKNOWN_BUS;
                    n_state  = S_LOAD;
                end else begin
                    n_joint = r_joint + JIDX_W'(1);
                end
            end
            S_MOTOR: begin
                if (!i_alu_flags.zero) begin
                    n_status = r_bad ? ST_NON_FINITE : ST_MOTOR_MISMATCH;
                    n_state  = S_LOAD;
                end else begin
                    n_state = S_TIME;
                end
            end
            S_TIME: begin
                if (r_bad) begin
                    n_status = ST_NON_FINITE;
                end else if (i_store_rsp.valid && (i_alu_flags.borrow || i_alu_flags.zero)) begin
                    n_status = ST_STALE;
                end else begin
                    n_status       = ST_OK;
                    o_store_req.we = 1'b1;
                    n_gen          = r_gen + 32'd1;
                    n_active       = 1'b1;
                end
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_out_status = r_status;
                n_out_joint  = r_have ? 3'(r_joint) : 3'd0;
                n_out_last   = 1'b1;
                n_out_fresh  = 1'b0;
                n_out_entry  = r_have ? i_store_rsp.entry : '0;
                n_out_valid  = 1'b1;
                n_state      = S_HOLD;
            end
            S_SNAP: begin
                n_diff  = i_alu_diff;
                n_nb    = !i_alu_flags.borrow;
                n_state = S_AGE;
            end
            S_AGE: begin
                n_out_status = ST_OK;
                n_out_joint  = 3'(r_joint);
                n_out_last   = (r_joint == LAST_JOINT);
                n_out_fresh  = i_store_rsp.valid && r_nb && !i_alu_flags.borrow;
                n_out_entry  = i_store_rsp.entry;
                n_out_valid  = 1'b1;
                n_state      = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_op == OP_SNAPSHOT && !r_out_last) begin
                        n_joint = r_joint + JIDX_W'(1);
                        n_state = S_SNAP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_bus        <= n_bus;
        r_motor      <= n_motor;
        r_sample     <= n_sample;
        r_bad        <= n_bad;
        r_have       <= n_have;
        r_joint      <= n_joint;
        r_status     <= n_status;
        r_diff       <= n_diff;
        r_nb         <= n_nb;
        r_out_status <= n_out_status;
        r_out_joint  <= n_out_joint;
        r_out_last   <= n_out_last;
        r_out_fresh  <= n_out_fresh;
        r_out_entry  <= n_out_entry;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_joint      = r_out_joint;
    assign o_last       = r_out_last;
    assign o_fresh      = r_out_fresh;
    assign o_generation = r_gen;
    assign o_bus_active = r_active;
    assign o_entry      = r_out_entry;

endmodule

FILE: rtl/joint_feedback_table_core.sv
// update: joint scan for the bus id, on a match a motor check, on a motor match a time check,
// all through the shared subtract unit, then result load
// snapshot: for each joint result, elapsed time, then age against the limit,
// plus the output handshake; one request at a time, ready only while idle
// reset: synchronous active low; clears valid flags, counters and output valid, config to defaults
module joint_feedback_table_core import jft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [55:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [10:0] i_bus_id,
    input  logic [7:0]  i_motor_id,
    input  logic [63:0] i_time_us,
    input  logic [31:0] i_position,
    input  logic [31:0] i_velocity,
    input  logic [31:0] i_torque,
    input  logic [31:0] i_driver_temp,
    input  logic [31:0] i_rotor_temp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_joint,
    output logic        o_last,
    output logic        o_fresh,
    output logic [31:0] o_generation_out,
    output logic        o_bus_active_out,
    output logic [63:0] o_sample_time_us,
    output logic [31:0] o_position_out,
    output logic [31:0] o_velocity_out,
    output logic [31:0] o_torque_out,
    output logic [31:0] o_driver_temp_out,
    output logic [31:0] o_rotor_temp_out
);

`include "joint_feedback_table_core_assert.svh"

    t_cfg        r_cfg;
    t_entry      w_sample;
    t_entry      w_out_entry;
    logic [63:0] w_alu_a, w_alu_b, w_alu_diff;
    t_alu_flags  w_alu_flags;
    t_store_req  w_store_req;
    t_store_rsp  w_store_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_ids_low    <= '0;
            r_cfg.bus_ids_high   <= '0;
            r_cfg.motor_ids      <= '0;
            r_cfg.stale_limit_us <= 32'd100000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BUS_IDS_LOW:  r_cfg.bus_ids_low    <= i_cfg_data[43:0];
                CFG_BUS_IDS_HIGH: r_cfg.bus_ids_high   <= i_cfg_data[32:0];
                CFG_MOTOR_IDS:    r_cfg.motor_ids      <= i_cfg_data[55:0];
                CFG_STALE_LIMIT:  r_cfg.stale_limit_us <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign w_sample.time_us     = i_time_us;
    assign w_sample.position    = i_position;
    assign w_sample.velocity    = i_velocity;
    assign w_sample.torque      = i_torque;
    assign w_sample.driver_temp = i_driver_temp;
    assign w_sample.rotor_temp  = i_rotor_temp;

    jft_alu u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .o_diff  (w_alu_diff),
        .o_flags (w_alu_flags)
    );

    jft_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_store_req),
        .o_rsp   (w_store_rsp)
    );

    jft_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_bus_id     (i_bus_id),
        .i_motor_id   (i_motor_id),
        .i_sample     (w_sample),
        .o_alu_a      (w_alu_a),
        .o_alu_b      (w_alu_b),
        .i_alu_diff   (w_alu_diff),
        .i_alu_flags  (w_alu_flags),
        .o_store_req  (w_store_req),
        .i_store_rsp  (w_store_rsp),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_joint      (o_joint),
        .o_last       (o_last),
        .o_fresh      (o_fresh),
        .o_generation (o_generation_out),
        .o_bus_active (o_bus_active_out),
        .o_entry      (w_out_entry)
    );

    assign o_sample_time_us  = w_out_entry.time_us;
    assign o_position_out    = w_out_entry.position;
    assign o_velocity_out    = w_out_entry.velocity;
    assign o_torque_out      = w_out_entry.torque;
    assign o_driver_temp_out = w_out_entry.driver_temp;
    assign o_rotor_temp_out  = w_out_entry.rotor_temp;

    `JFT_ASSERT_IMP(a_no_ready_while_result, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `JFT_ASSERT_NXT(a_busy_after_request, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `JFT_ASSERT_IMP(a_fresh_needs_active, i_clk, i_rst_n, o_out_valid && o_fresh,
        o_bus_active_out && o_status == ST_OK)
    `JFT_ASSERT_IMP(a_unknown_bus_zero, i_clk, i_rst_n, o_out_valid && o_status == ST_UNKNOWN_BUS,
        o_joint == 3'd0 && o_sample_time_us == 64'd0 && o_last)

endmodule

FILE: tb/sv/tb_joint_feedback_table_core.sv
// self-checking testbench for joint_feedback_table_core: directed table then random requests,
// every result compared against a cycle-free model of the joint table
// depends on jft_pkg and the joint_feedback_table_core rtl
module tb_joint_feedback_table_core;
    import jft_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 46;
    localparam logic [31:0] STALE_RESET_US = 32'd100000;

    typedef struct packed {
        logic        op;
        logic [10:0] bus;
        logic [7:0]  motor;
        t_entry      body;
    } fb_req_t;

    typedef struct packed {
        t_status     status;
        logic [2:0]  joint;
        logic        last;
        logic        fresh;
        logic [31:0] gen;
        logic        active;
        t_entry      entry;
    } fb_result_t;

    typedef struct {
        bit          is_cfg;
        t_cfg_reg    sel;
        logic [55:0] cfg_val;
        fb_req_t     req;
        bit          pin;
        t_status     pin_status;
        logic [2:0]  pin_joint;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [55:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_operation = 1'b0;
    logic [10:0] i_bus_id = '0;
    logic [7:0]  i_motor_id = '0;
    logic [63:0] i_time_us = '0;
    logic [31:0] i_position = '0;
    logic [31:0] i_velocity = '0;
    logic [31:0] i_torque = '0;
    logic [31:0] i_driver_temp = '0;
    logic [31:0] i_rotor_temp = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [2:0]  o_joint;
    logic        o_last;
    logic        o_fresh;
    logic [31:0] o_generation_out;
    logic        o_bus_active_out;
    logic [63:0] o_sample_time_us;
    logic [31:0] o_position_out;
    logic [31:0] o_velocity_out;
    logic [31:0] o_torque_out;
    logic [31:0] o_driver_temp_out;
    logic [31:0] o_rotor_temp_out;

    t_cfg                   shadow_cfg;
    t_entry                 shadow_entry [JOINT_COUNT];
    logic [JOINT_COUNT-1:0] shadow_valid;
    logic [31:0]            shadow_gen;
    logic                   shadow_active;
    fb_result_t             awaited_results [$];

    int unsigned send_idle_pct = 9;
    int unsigned recv_idle_pct = 61;
    bit          pin_on = 1'b0;
    t_status     pin_status = ST_OK;
    logic [2:0]  pin_joint = '0;
    int          err_count = 0;
    int          requests_taken = 0;
    int          updates_taken = 0;
    int          snapshots_taken = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    int          quiet_cycles = 0;
    int          outcome_tally [5] = '{default: 0};

    joint_feedback_table_core u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [10:0] bus_of(input int j);
        if (j < 4) return 11'(shadow_cfg.bus_ids_low >> (11 * j));
        if (j < 7) return 11'(shadow_cfg.bus_ids_high >> (11 * (j - 4)));
        return '0;
    endfunction

    function automatic logic [7:0] motor_of(input int j);
        if (j < 7) return 8'(shadow_cfg.motor_ids >> (8 * j));
        return '0;
    endfunction

    function automatic int first_joint(input logic [10:0] bus);
        for (int j = 0; j < JOINT_COUNT; j++)
            if (bus_of(j) == bus) return j;
        return -1;
    endfunction

    function automatic bit exp_all_ones(input logic [31:0] w);
        return w[30:23] == 8'hFF;
    endfunction

    function automatic logic [31:0] finite_word();
        logic [31:0] w;
        w = $urandom;
        if (exp_all_ones(w)) w[23] = 1'b0;
        return w;
    endfunction

    task automatic predict_table_response(input fb_req_t r);
        fb_result_t  res;
        int          hit;
        bit          bad;
        t_status     st;
        logic [63:0] ts;
        if (r.op == OP_UPDATE) begin
            res = '0;
            bad = exp_all_ones(r.body.position) || exp_all_ones(r.body.velocity) ||
                  exp_all_ones(r.body.torque) || exp_all_ones(r.body.driver_temp) ||
                  exp_all_ones(r.body.rotor_temp);
            hit = first_joint(r.bus);
            if (bad) st = ST_NON_FINITE;
            else if (hit < 0) st = ST_UNKNOWN_BUS;
            else if (motor_of(hit) != r.motor) st = ST_MOTOR_MISMATCH;
            else if (shadow_valid[hit] && r.body.time_us <= shadow_entry[hit].time_us)
                st = ST_STALE;
            else begin
                st = ST_OK;
                shadow_entry[hit] = r.body;
                shadow_valid[hit] = 1'b1;
                shadow_active = 1'b1;
                shadow_gen = shadow_gen + 32'd1;
            end
            outcome_tally[int'(st)]++;
            res.status = st;
            res.last = 1'b1;
            res.gen = shadow_gen;
            res.active = shadow_active;
            if (hit >= 0) begin
                res.joint = 3'(hit);
                res.entry = shadow_entry[hit];
            end
            awaited_results.push_back(res);
        end else begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
                res = '0;
                ts = shadow_entry[j].time_us;
                res.status = ST_OK;
                res.joint = 3'(j);
                res.last = (j == JOINT_COUNT - 1);
                res.fresh = shadow_valid[j] && r.body.time_us >= ts &&
                            (r.body.time_us - ts) <= 64'(shadow_cfg.stale_limit_us);
                res.gen = shadow_gen;
                res.active = shadow_active;
                res.entry = shadow_entry[j];
                awaited_results.push_back(res);
            end
        end
    endtask

    task automatic note_error(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want_v);
        if (got !== want_v)
            note_error($sformatf("result %0d %s: got %0h, want %0h",
                                 results_seen, name, got, want_v));
    endtask

    always @(posedge i_clk) begin
        fb_req_t    incoming;
        fb_result_t want;
        if (!i_rst_n) begin
            shadow_cfg = '0;
            shadow_cfg.stale_limit_us = STALE_RESET_US;
            foreach (shadow_entry[j]) shadow_entry[j] = '0;
            shadow_valid = '0;
            shadow_gen = '0;
            shadow_active = 1'b0;
        end else begin
            if (i_cfg_we) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_BUS_IDS_LOW:  shadow_cfg.bus_ids_low    = i_cfg_data[43:0];
                    CFG_BUS_IDS_HIGH: shadow_cfg.bus_ids_high   = i_cfg_data[32:0];
                    CFG_MOTOR_IDS:    shadow_cfg.motor_ids      = i_cfg_data;
                    CFG_STALE_LIMIT:  shadow_cfg.stale_limit_us = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                incoming.op = i_operation;
                incoming.bus = i_bus_id;
                incoming.motor = i_motor_id;
                incoming.body.time_us = i_time_us;
                incoming.body.position = i_position;
                incoming.body.velocity = i_velocity;
                incoming.body.torque = i_torque;
                incoming.body.driver_temp = i_driver_temp;
                incoming.body.rotor_temp = i_rotor_temp;
                predict_table_response(incoming);
                if (pin_on) begin
                    awaited_results[awaited_results.size() - 1].status = pin_status;
                    awaited_results[awaited_results.size() - 1].joint = pin_joint;
                end
                if (i_operation == OP_UPDATE) updates_taken++;
                else snapshots_taken++;
                requests_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    note_error($sformatf("result for joint %0d with no request pending",
                                         o_joint));
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", o_status, want.status);
                    check_field("joint", o_joint, want.joint);
                    check_field("last", o_last, want.last);
                    check_field("fresh", o_fresh, want.fresh);
                    check_field("generation", o_generation_out, want.gen);
                    check_field("bus_active", o_bus_active_out, want.active);
                    check_field("sample_time", o_sample_time_us, want.entry.time_us);
                    check_field("position", o_position_out, want.entry.position);
                    check_field("velocity", o_velocity_out, want.entry.velocity);
                    check_field("torque", o_torque_out, want.entry.torque);
                    check_field("driver_temp", o_driver_temp_out, want.entry.driver_temp);
                    check_field("rotor_temp", o_rotor_temp_out, want.entry.rotor_temp);
                end
                results_seen++;
            end
        end
    end

    always @(negedge i_clk) i_out_ready = ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("stalled %0d cycles with %0d results pending",
                     quiet_cycles, awaited_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(input fb_req_t r);
        int seen;
        seen = requests_taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_operation = r.op;
        i_bus_id = r.bus;
        i_motor_id = r.motor;
        i_time_us = r.body.time_us;
        i_position = r.body.position;
        i_velocity = r.body.velocity;
        i_torque = r.body.torque;
        i_driver_temp = r.body.driver_temp;
        i_rotor_temp = r.body.rotor_temp;
        i_in_valid = 1'b1;
        do @(negedge i_clk); while (requests_taken == seen);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [55:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = sel;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_random_config(input logic [31:0] limit);
        logic [10:0] ids [7];
        for (int j = 0; j < 7; j++)
            ids[j] = (j > 0 && $urandom_range(3) == 0) ? ids[j - 1] : 11'($urandom);
        write_reg(CFG_BUS_IDS_LOW, {12'($urandom), ids[3], ids[2], ids[1], ids[0]});
        write_reg(CFG_BUS_IDS_HIGH, {23'($urandom), ids[6], ids[5], ids[4]});
        write_reg(CFG_MOTOR_IDS, 56'({$urandom, $urandom}));
        write_reg(CFG_STALE_LIMIT, {24'($urandom), limit});
    endtask

    task automatic make_random_request(output fb_req_t r);
        int          roll;
        int          k;
        int          hit;
        logic [63:0] held;
        logic [63:0] lim;
        roll = $urandom_range(99);
        r.op = OP_UPDATE;
        r.bus = 11'($urandom);
        r.motor = 8'($urandom);
        r.body.time_us = {$urandom, $urandom};
        r.body.position = finite_word();
        r.body.velocity = finite_word();
        r.body.torque = finite_word();
        r.body.driver_temp = finite_word();
        r.body.rotor_temp = finite_word();
        k = $urandom_range(JOINT_COUNT - 1);
        if (roll < 15) begin
            r.op = OP_SNAPSHOT;
            held = shadow_entry[k].time_us;
            lim = 64'(shadow_cfg.stale_limit_us);
            case ($urandom_range(3))
                0: r.body.time_us = held + lim;
                1: r.body.time_us = held + lim + 64'd1;
                2: r.body.time_us = held + 64'($urandom_range(0, 1000));
                default: ;
            endcase
        end else if (roll >= 25) begin
            r.bus = bus_of(k);
            if (roll >= 33) r.motor = motor_of(k);
            hit = first_joint(r.bus);
            held = shadow_entry[hit].time_us;
            case ($urandom_range(19))
                0, 1, 2: ;
                3, 4:    r.body.time_us = held;
                5:       r.body.time_us = held - 64'd1;
                default: r.body.time_us = held + 64'($urandom_range(1, 250000));
            endcase
            if (roll >= 33 && roll < 41) begin
                case ($urandom_range(4))
                    0: r.body.position[30:23] = 8'hFF;
                    1: r.body.velocity[30:23] = 8'hFF;
                    2: r.body.torque[30:23] = 8'hFF;
                    3: r.body.driver_temp[30:23] = 8'hFF;
                    default: r.body.rotor_temp[30:23] = 8'hFF;
                endcase
            end
        end
    endtask

    function automatic fb_req_t upd(input logic [10:0] bus, input logic [7:0] mot,
                                    input logic [63:0] t,
                                    input logic [31:0] p, v, q, d, rt);
        fb_req_t r;
        r.op = OP_UPDATE;
        r.bus = bus;
        r.motor = mot;
        r.body = '{t, p, v, q, d, rt};
        return r;
    endfunction

    function automatic fb_req_t snap(input logic [63:0] t);
        fb_req_t r;
        r = '0;
        r.op = OP_SNAPSHOT;
        r.body.time_us = t;
        return r;
    endfunction

    function automatic dir_row_t as_row(input fb_req_t r);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.sel = CFG_BUS_IDS_LOW;
        row.cfg_val = '0;
        row.req = r;
        row.pin = 1'b0;
        row.pin_status = ST_OK;
        row.pin_joint = '0;
        return row;
    endfunction

    function automatic dir_row_t pinned(input fb_req_t r, input t_status s,
                                        input logic [2:0] j);
        dir_row_t row;
        row = as_row(r);
        row.pin = 1'b1;
        row.pin_status = s;
        row.pin_joint = j;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input t_cfg_reg sel, input logic [55:0] val);
        dir_row_t row;
        row = as_row(snap('0));
        row.is_cfg = 1'b1;
        row.sel = sel;
        row.cfg_val = val;
        return row;
    endfunction

    initial begin
        dir_row_t    dir_rows [$];
        fb_req_t     item;
        logic [31:0] limit;
        logic [31:0] one_f;
        logic [63:0] t_max;
        one_f = 32'h3F80_0000;
        t_max = '1;

        // reset defaults: every joint on bus 0 with motor 0
        dir_rows.push_back(as_row(snap(64'd0)));
        dir_rows.push_back(pinned(upd(11'h000, 8'h00, 64'd0, '0, '0, '0, '0, '0),
                                  ST_OK, 3'd0));
        dir_rows.push_back(pinned(upd(11'h000, 8'h00, 64'd0, one_f, one_f, one_f, one_f,
                                      one_f), ST_STALE, 3'd0));
        dir_rows.push_back(pinned(upd(11'h000, 8'h01, 64'd10, one_f, one_f, one_f, one_f,
                                      one_f), ST_MOTOR_MISMATCH, 3'd0));
        dir_rows.push_back(pinned(upd(11'h005, 8'h00, 64'd10, one_f, one_f, one_f, one_f,
                                      one_f), ST_UNKNOWN_BUS, 3'd0));
        dir_rows.push_back(pinned(upd(11'h000, 8'h00, 64'd10, 32'h7F80_0000, one_f, one_f,
                                      one_f, one_f), ST_NON_FINITE, 3'd0));
        dir_rows.push_back(as_row(snap(64'd100000)));
        dir_rows.push_back(as_row(snap(64'd100001)));

        // joint 5 shares its bus with joint 2, joint 3 sits on bus 0
        dir_rows.push_back(cfg_row(CFG_BUS_IDS_LOW,
                                   {12'h000, 11'h000, 11'h2AA, 11'h155, 11'h001}));
        dir_rows.push_back(cfg_row(CFG_BUS_IDS_HIGH, {23'h0, 11'h7FF, 11'h2AA, 11'h3C3}));
        dir_rows.push_back(cfg_row(CFG_MOTOR_IDS,
                                   {8'hFF, 8'h15, 8'h14, 8'h13, 8'h12, 8'h11, 8'h00}));
        dir_rows.push_back(cfg_row(CFG_STALE_LIMIT, 56'd0));
        dir_rows.push_back(pinned(upd(11'h7FF, 8'hFF, t_max, 32'hFF7F_FFFF, 32'hFF7F_FFFF,
                                      32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'hFF7F_FFFF),
                                  ST_OK, 3'd6));
        dir_rows.push_back(pinned(upd(11'h7FF, 8'hFF, t_max, one_f, one_f, one_f, one_f,
                                      one_f), ST_STALE, 3'd6));
        dir_rows.push_back(pinned(upd(11'h2AA, 8'h12, 64'd100, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                                      32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF),
                                  ST_OK, 3'd2));
        dir_rows.push_back(pinned(upd(11'h2AA, 8'h15, 64'd200, one_f, one_f, one_f, one_f,
                                      one_f), ST_MOTOR_MISMATCH, 3'd2));
        dir_rows.push_back(pinned(upd(11'h000, 8'h13, 64'd0, one_f, one_f, one_f, one_f,
                                      32'hFF80_0000), ST_NON_FINITE, 3'd3));
        dir_rows.push_back(pinned(upd(11'h123, 8'h00, 64'd5, one_f, 32'h7FC0_0000, one_f,
                                      one_f, one_f), ST_NON_FINITE, 3'd0));
        dir_rows.push_back(pinned(upd(11'h155, 8'h11, 64'd7, one_f, one_f, 32'h7F80_0001,
                                      one_f, one_f), ST_NON_FINITE, 3'd1));
        dir_rows.push_back(pinned(upd(11'h3C3, 8'h14, 64'd9, one_f, one_f, one_f,
                                      32'hFFFF_FFFF, one_f), ST_NON_FINITE, 3'd4));
        dir_rows.push_back(pinned(upd(11'h001, 8'h00, 64'd50, 32'h4049_0FDB, 32'hC000_0000,
                                      32'h0000_0001, 32'h41C8_0000, 32'h4220_0000),
                                  ST_OK, 3'd0));
        dir_rows.push_back(pinned(upd(11'h000, 8'h13, 64'h8000_0000_0000_0000, one_f,
                                      one_f, one_f, one_f, one_f), ST_OK, 3'd3));
        dir_rows.push_back(as_row(snap(64'd50)));
        dir_rows.push_back(cfg_row(CFG_STALE_LIMIT, 56'hFFFF_FFFF));
        dir_rows.push_back(as_row(snap(t_max)));
        dir_rows.push_back(pinned(upd(11'h2AA, 8'h12, 64'd100, one_f, one_f, one_f, one_f,
                                      one_f), ST_STALE, 3'd2));
        dir_rows.push_back(pinned(upd(11'h3C3, 8'h14, 64'd1, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                                  ST_OK, 3'd4));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg) begin
                settle();
                write_reg(dir_rows[n].sel, dir_rows[n].cfg_val);
            end else begin
                pin_on = dir_rows[n].pin;
                pin_status = dir_rows[n].pin_status;
                pin_joint = dir_rows[n].pin_joint;
                send_request(dir_rows[n].req);
            end
        end
        pin_on = 1'b0;

        for (int phase = 0; phase < 3; phase++) begin
            settle();
            case (phase)
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 9;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                default: ;
            endcase
            limit = (phase == 0) ? 32'($urandom_range(1, 200000)) :
                    (phase == 1) ? 32'd0 : 32'hFFFF_FFFF;
            load_random_config(limit);
            repeat (ITEMS_PER_PHASE) begin
                make_random_request(item);
                send_request(item);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d requests (%0d updates, %0d snapshots), %0d results, %0d reg writes",
                 requests_taken, updates_taken, snapshots_taken, results_seen, cfg_writes);
        $display("update outcomes ok/non-finite/unknown/motor/stale: %0d/%0d/%0d/%0d/%0d",
                 outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3],
                 outcome_tally[4]);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
